FILE: rtl/qpg_pkg.sv
// Package for the quadrilateral panel geometry block.
// Holds the result kind codes, the result record and the pipeline latency
// of the normalization unit. No dependencies.
package qpg_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_COORD = 12;
  localparam int NUM_RES   = 6;
  localparam int MAG_W     = 30;

  typedef enum logic [2:0] {
    KIND_CENTROID = 3'd0,
    KIND_LONG     = 3'd1,
    KIND_TRANS    = 3'd2,
    KIND_NORMAL   = 3'd3,
    KIND_PERP     = 3'd4,
    KIND_AREA     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              deg;
  } res_t;

  // Register stages from the vector input of the normalization unit to its
  // outputs: four front stages, 31 square root steps, one divider load,
  // one step per quotient bit and the output register.
  function automatic int norm_lat(input int frac_bits);
    return frac_bits + 38;
  endfunction

endpackage

FILE: rtl/qpg_norm.sv
// Pipelined vector normalization unit for the panel geometry block.
// Scales, takes the integer square root of the squared length bit by bit and
// divides bit by bit. Depends on qpg_pkg.
module qpg_norm import qpg_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int VW        = 62
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [VW-1:0]        vec_i [3],
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output logic                        zero_o,
  output logic signed [7:0]           shift_o,
  output logic [30:0]                 len_o
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = MAG_W + FRAC_BITS + 1;
  localparam int SQS = 31;

  typedef struct packed {
    logic [2:0]        neg;
    logic              zero;
    logic signed [7:0] sh;
  } side_t;

  logic [VW-1:0]          mag1_q [3];
  logic [VW-1:0]          mx1_q;
  logic [2:0]             neg1_q;
  logic [MAG_W-1:0]       a2_q [3];
  side_t                  sd2_q;
  logic [2*MAG_W-1:0]     sq3_q [3];
  logic [MAG_W-1:0]       a3_q [3];
  side_t                  sd3_q;

  logic [61:0]            sx_q   [SQS+1];
  logic [32:0]            srem_q [SQS+1];
  logic [30:0]            sr_q   [SQS+1];
  logic [MAG_W-1:0]       sa_q   [SQS+1][3];
  side_t                  ssd_q  [SQS+1];

  logic [30:0]            dr_q  [QW+1][3];
  logic [QW-1:0]          dnl_q [QW+1][3];
  logic [QW-1:0]          dq_q  [QW+1][3];
  logic [30:0]            dn_q  [QW+1];
  side_t                  dsd_q [QW+1];

  logic signed [UW-1:0]   unit_q [3];
  logic                   zero_q;
  logic signed [7:0]      sh_q;
  logic [30:0]            len_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
        neg1_q[i] <= vec_i[i][VW-1];
      end
    end
  end

  always_comb begin
    logic [VW-1:0] m01;
    m01 = (mag1_q[0] > mag1_q[1]) ? mag1_q[0] : mag1_q[1];
    mx1_q = (m01 > mag1_q[2]) ? m01 : mag1_q[2];
  end

  always_ff @(posedge clk_i) begin
    logic [6:0]        p;
    logic signed [7:0] sh;
    logic [5:0]        amt;
    logic [VW-1:0]     tmp;
    if (en_i) begin
      p = '0;
      for (int b = 0; b < VW; b++) begin
        if (mx1_q[b]) p = 7'(b);
      end
      sh = $signed({1'b0, p}) - 8'sd29;
      for (int i = 0; i < 3; i++) begin
        if (sh > 8'sd0) begin
          amt = 6'(sh);
          tmp = mag1_q[i] >> amt;
        end else begin
          amt = 6'(-sh);
          tmp = mag1_q[i] << amt;
        end
        a2_q[i] <= tmp[MAG_W-1:0];
      end
      sd2_q.neg  <= neg1_q;
      sd2_q.zero <= (mx1_q == '0);
      sd2_q.sh   <= (mx1_q == '0) ? 8'sd0 : sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= a2_q[i] * a2_q[i];
        a3_q[i]  <= a2_q[i];
      end
      sd3_q <= sd2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0]   <= 62'(sq3_q[0]) + 62'(sq3_q[1]) + 62'(sq3_q[2]);
      srem_q[0] <= '0;
      sr_q[0]   <= '0;
      sa_q[0]   <= a3_q;
      ssd_q[0]  <= sd3_q;
    end
  end

  for (genvar k = 1; k <= SQS; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      logic [34:0] trial;
      logic [34:0] t;
      if (en_i) begin
        trial = {srem_q[k-1], sx_q[k-1][61:60]};
        t     = {2'b00, sr_q[k-1], 2'b01};
        if (trial >= t) begin
          srem_q[k] <= 33'(trial - t);
          sr_q[k]   <= {sr_q[k-1][29:0], 1'b1};
        end else begin
          srem_q[k] <= trial[32:0];
          sr_q[k]   <= {sr_q[k-1][29:0], 1'b0};
        end
        sx_q[k]  <= {sx_q[k-1][59:0], 2'b00};
        sa_q[k]  <= sa_q[k-1];
        ssd_q[k] <= ssd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NW-1:0] num;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num = (NW'(sa_q[SQS][i]) << FRAC_BITS) + NW'(sr_q[SQS] >> 1);
        dr_q[0][i]  <= 31'(num >> QW);
        dnl_q[0][i] <= num[QW-1:0];
        dq_q[0][i]  <= '0;
      end
      dn_q[0]  <= sr_q[SQS];
      dsd_q[0] <= ssd_q[SQS];
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [31:0] t;
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          t = {dr_q[k-1][i], dnl_q[k-1][i][QW-1]};
          if (t >= {1'b0, dn_q[k-1]}) begin
            dr_q[k][i] <= 31'(t - {1'b0, dn_q[k-1]});
            dq_q[k][i] <= {dq_q[k-1][i][QW-2:0], 1'b1};
          end else begin
            dr_q[k][i] <= t[30:0];
            dq_q[k][i] <= {dq_q[k-1][i][QW-2:0], 1'b0};
          end
          dnl_q[k][i] <= {dnl_q[k-1][i][QW-2:0], 1'b0};
        end
        dn_q[k]  <= dn_q[k-1];
        dsd_q[k] <= dsd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [UW-1:0] q;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        q = $signed(UW'(dq_q[QW][i]));
        if (dsd_q[QW].zero) begin
          unit_q[i] <= '0;
        end else if (dsd_q[QW].neg[i]) begin
          unit_q[i] <= -q;
        end else begin
          unit_q[i] <= q;
        end
      end
      zero_q <= dsd_q[QW].zero;
      sh_q   <= dsd_q[QW].sh;
      len_q  <= dn_q[QW];
    end
  end

  assign unit_o  = unit_q;
  assign zero_o  = zero_q;
  assign shift_o = sh_q;
  assign len_o   = len_q;

endmodule

FILE: rtl/quad_panel_geometry.sv
// Quadrilateral panel geometry: corners in, six geometry results out.
// Top level; uses qpg_pkg and three qpg_norm units.
//
// Usage: each slave-side transaction carries the twelve corner coordinates
// of one panel (signed Q16.16, corner 0 x in the lowest bits). For every
// panel the master side gives six transactions in order: centroid, unit
// longitudinal, unit transverse, unit normal, n x l and area. tuser carries
// the kind and the degenerate flag; tlast marks the area result.
// A panel's corners pass through four front stages, the normalization
// pipeline with its bit-serial square root and divider, and two stages for
// n x l and area before its first result appears. The single result channel
// sets the throughput, giving six results per panel; the pipeline takes a
// new panel in any cycle in which the result register is free or is giving
// up its last result.
// Reset clears all valid bits; no result is pending afterwards.
// When the receiver stalls, the whole pipeline holds, and data is neither
// lost nor repeated; the slave side drops tready while the held panel
// still has results waiting.
module quad_panel_geometry import qpg_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // c0_x, c0_y, c0_z, c1_x, ... c3_z, 32 bits each, from the lowest bit up.
  input  logic [NUM_COORD*DATA_W-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // res_x, res_y, res_z, 32 bits each, from the lowest bit up.
  output logic [3*DATA_W-1:0]           m_axis_tdata_o,
  // kind (3 bits), degenerate (1 bit), from the lowest bit up.
  output logic [3:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  localparam int CW  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int UW  = FRAC_BITS + 2;
  localparam int LAT = norm_lat(FRAC_BITS);
  localparam logic [63:0] MAXV = (64'd1 << (CW - 1)) - 64'd1;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic en;
  logic beat;

  logic                v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [2:0]          cnt_q;

  logic signed [31:0]  cg1_q [3];
  logic signed [33:0]  lv1_q [3], tv1_q [3];
  logic signed [32:0]  d11_q [3], d21_q [3];

  logic signed [31:0]  cg2_q [3];
  logic signed [33:0]  lv2_q [3], tv2_q [3];
  logic signed [30:0]  e12_q [3], e22_q [3];
  logic [2:0]          ss2_q;

  logic signed [31:0]  cg3_q [3];
  logic signed [33:0]  lv3_q [3], tv3_q [3];
  logic signed [61:0]  pr3_q [6];
  logic [2:0]          ss3_q;

  logic signed [31:0]  cg4_q [3];
  logic signed [33:0]  lv4_q [3], tv4_q [3];
  logic signed [61:0]  cr4_q [3];
  logic [2:0]          ss4_q;

  logic                dv_q  [LAT];
  logic signed [31:0]  dcg_q [LAT][3];
  logic [2:0]          dss_q [LAT];

  logic signed [UW-1:0] ul [3], ut [3], un [3];
  logic                 zl, zt, zn;
  logic signed [7:0]    shl, sht, shn;
  logic [30:0]          nl, nt, nn;

  logic signed [31:0]   cg5_q [3];
  logic signed [UW-1:0] ul5_q [3], ut5_q [3], un5_q [3];
  logic                 dl5_q, dt5_q, dn5_q;
  logic signed [2*UW-1:0] pp5_q [6];
  logic [31:0]          ar5_q;
  logic                 da5_q;

  res_t                 r6_q [NUM_RES];
  res_t                 cur;

  assign beat            = m_axis_tvalid_o & m_axis_tready_i;
  assign en              = !v6_q || (beat && cnt_q == 3'(KIND_AREA));
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      cnt_q <= '0;
      for (int i = 0; i < LAT; i++) dv_q[i] <= 1'b0;
    end else begin
      if (en) begin
        v1_q    <= s_axis_tvalid_i;
        v2_q    <= v1_q;
        v3_q    <= v2_q;
        v4_q    <= v3_q;
        dv_q[0] <= v4_q;
        for (int i = 1; i < LAT; i++) dv_q[i] <= dv_q[i-1];
        v5_q    <= dv_q[LAT-1];
        v6_q    <= v5_q;
      end
      if (beat) begin
        cnt_q <= (cnt_q == 3'(KIND_AREA)) ? 3'd0 : cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [33:0] c [4][3];
    logic signed [33:0] sum;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          c[k][j] = 34'($signed(s_axis_tdata_i[(k*3+j)*DATA_W +: CW]));
        end
      end
      for (int j = 0; j < 3; j++) begin
        sum = c[0][j] + c[1][j] + c[2][j] + c[3][j];
        cg1_q[j] <= 32'(sum >>> 2);
        lv1_q[j] <= c[0][j] + c[3][j] - c[1][j] - c[2][j];
        tv1_q[j] <= c[2][j] + c[3][j] - c[0][j] - c[1][j];
        d11_q[j] <= 33'(c[2][j] - c[0][j]);
        d21_q[j] <= 33'(c[1][j] - c[3][j]);
      end
    end
  end

  function automatic logic [1:0] shrink_amt(input logic [32:0] m);
    if (m >= 33'h100000000)     return 2'd3;
    else if (m >= 33'h80000000) return 2'd2;
    else if (m >= 33'h40000000) return 2'd1;
    else                        return 2'd0;
  endfunction

  always_ff @(posedge clk_i) begin
    logic [32:0] m1 [3], m2 [3];
    logic [32:0] x1, x2;
    logic [1:0]  k1, k2;
    logic [30:0] q;
    if (en) begin
      x1 = '0;
      x2 = '0;
      for (int j = 0; j < 3; j++) begin
        m1[j] = d11_q[j][32] ? 33'(-d11_q[j]) : 33'(d11_q[j]);
        m2[j] = d21_q[j][32] ? 33'(-d21_q[j]) : 33'(d21_q[j]);
        if (m1[j] > x1) x1 = m1[j];
        if (m2[j] > x2) x2 = m2[j];
      end
      k1 = shrink_amt(x1);
      k2 = shrink_amt(x2);
      for (int j = 0; j < 3; j++) begin
        q = 31'(m1[j] >> k1);
        e12_q[j] <= d11_q[j][32] ? -$signed(q) : $signed(q);
        q = 31'(m2[j] >> k2);
        e22_q[j] <= d21_q[j][32] ? -$signed(q) : $signed(q);
      end
      ss2_q <= 3'(k1) + 3'(k2);
      cg2_q <= cg1_q;
      lv2_q <= lv1_q;
      tv2_q <= tv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr3_q[0] <= e12_q[1] * e22_q[2];
      pr3_q[1] <= e12_q[2] * e22_q[1];
      pr3_q[2] <= e12_q[2] * e22_q[0];
      pr3_q[3] <= e12_q[0] * e22_q[2];
      pr3_q[4] <= e12_q[0] * e22_q[1];
      pr3_q[5] <= e12_q[1] * e22_q[0];
      ss3_q <= ss2_q;
      cg3_q <= cg2_q;
      lv3_q <= lv2_q;
      tv3_q <= tv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr4_q[0] <= pr3_q[0] - pr3_q[1];
      cr4_q[1] <= pr3_q[2] - pr3_q[3];
      cr4_q[2] <= pr3_q[4] - pr3_q[5];
      ss4_q <= ss3_q;
      cg4_q <= cg3_q;
      lv4_q <= lv3_q;
      tv4_q <= tv3_q;
    end
  end

  qpg_norm #(.FRAC_BITS(FRAC_BITS), .VW(34)) u_norm_l (
    .clk_i, .en_i(en), .vec_i(lv4_q),
    .unit_o(ul), .zero_o(zl), .shift_o(shl), .len_o(nl)
  );

  qpg_norm #(.FRAC_BITS(FRAC_BITS), .VW(34)) u_norm_t (
    .clk_i, .en_i(en), .vec_i(tv4_q),
    .unit_o(ut), .zero_o(zt), .shift_o(sht), .len_o(nt)
  );

  qpg_norm #(.FRAC_BITS(FRAC_BITS), .VW(62)) u_norm_n (
    .clk_i, .en_i(en), .vec_i(cr4_q),
    .unit_o(un), .zero_o(zn), .shift_o(shn), .len_o(nn)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dcg_q[0] <= cg4_q;
      dss_q[0] <= ss4_q;
      for (int i = 1; i < LAT; i++) begin
        dcg_q[i] <= dcg_q[i-1];
        dss_q[i] <= dss_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [8:0] k;
    logic [8:0]        nk;
    logic [63:0]       big;
    if (en) begin
      pp5_q[0] <= un[1] * ul[2];
      pp5_q[1] <= un[2] * ul[1];
      pp5_q[2] <= un[2] * ul[0];
      pp5_q[3] <= un[0] * ul[2];
      pp5_q[4] <= un[0] * ul[1];
      pp5_q[5] <= un[1] * ul[0];
      k = 9'(shn) + $signed({6'b0, dss_q[LAT-1]}) - 9'sd1 - 9'(FRAC_BITS);
      nk = 9'(-k);
      big = '0;
      if (zn) begin
        ar5_q <= '0;
        da5_q <= 1'b0;
      end else if (!k[8] && k > 9'sd32) begin
        ar5_q <= 32'(MAXV);
        da5_q <= 1'b1;
      end else begin
        if (!k[8]) big = {33'b0, nn} << k[5:0];
        else       big = {33'b0, nn} >> nk[5:0];
        if (big > MAXV) begin
          ar5_q <= 32'(MAXV);
          da5_q <= 1'b1;
        end else begin
          ar5_q <= big[31:0];
          da5_q <= 1'b0;
        end
      end
      cg5_q <= dcg_q[LAT-1];
      ul5_q <= ul;
      ut5_q <= ut;
      un5_q <= un;
      dl5_q <= zl;
      dt5_q <= zt;
      dn5_q <= zn;
    end
  end

  function automatic logic [31:0] ext_unit(input logic signed [UW-1:0] u);
    return 32'(u);
  endfunction

  always_ff @(posedge clk_i) begin
    logic signed [63:0] pw [3];
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pw[j] = (64'(pp5_q[2*j]) - 64'(pp5_q[2*j+1]) + HALF) >>> FRAC_BITS;
      end
      r6_q[KIND_CENTROID] <= '{x: cg5_q[0], y: cg5_q[1], z: cg5_q[2], deg: 1'b0};
      r6_q[KIND_LONG]     <= '{x: ext_unit(ul5_q[0]), y: ext_unit(ul5_q[1]),
                               z: ext_unit(ul5_q[2]), deg: dl5_q};
      r6_q[KIND_TRANS]    <= '{x: ext_unit(ut5_q[0]), y: ext_unit(ut5_q[1]),
                               z: ext_unit(ut5_q[2]), deg: dt5_q};
      r6_q[KIND_NORMAL]   <= '{x: ext_unit(un5_q[0]), y: ext_unit(un5_q[1]),
                               z: ext_unit(un5_q[2]), deg: dn5_q};
      r6_q[KIND_PERP]     <= '{x: pw[0][31:0], y: pw[1][31:0], z: pw[2][31:0],
                               deg: dn5_q | dl5_q};
      r6_q[KIND_AREA]     <= '{x: ar5_q, y: 32'd0, z: 32'd0, deg: da5_q};
    end
  end

  always_comb begin
    unique case (cnt_q)
      3'(KIND_CENTROID): cur = r6_q[KIND_CENTROID];
      3'(KIND_LONG):     cur = r6_q[KIND_LONG];
      3'(KIND_TRANS):    cur = r6_q[KIND_TRANS];
      3'(KIND_NORMAL):   cur = r6_q[KIND_NORMAL];
      3'(KIND_PERP):     cur = r6_q[KIND_PERP];
      3'(KIND_AREA):     cur = r6_q[KIND_AREA];
      default:           cur = r6_q[KIND_AREA];
    endcase
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = {cur.z, cur.y, cur.x};
  assign m_axis_tuser_o  = {cur.deg, cnt_q};
  assign m_axis_tlast_o  = (cnt_q == 3'(KIND_AREA));

endmodule
